### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks on a clock with a synchronous, active-high reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Expression holds at every edge outside reset.
`define FB_ASSERT_HOLDS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define FB_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define FB_ASSERT_HOLDS(lbl, clk, rst, expr)
`define FB_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`endif

`endif

### hdl/fbpool_pkg.sv
// ----------------------------------------------------------------------------
// fbpool_pkg
// Shared types and constants of the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package fbpool_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CAP_W      = IDX_W + 1;
   localparam int LINK_W     = IDX_W + 1;   // tail flag above the next index
   localparam int POOL_W     = 21;
   localparam int BSIZE_W    = 17;
   localparam int OFS_W      = 20;
   localparam int CNT_W      = 11;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int FIDX_W     = 10;
   localparam int PROD_W     = IDX_W + BSIZE_W;
   localparam int DIV_STEPS  = POOL_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BSIZE_W-1:0] MIN_BLOCK_BYTES = BSIZE_W'(4);
   localparam logic [CNT_W-1:0]   COUNT_MAX       = {CNT_W{1'b1}};

   // item modes
   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INIT  = 2'd2;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_OWNED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_SETUP = 2'd3;

   // register select, taken from paddr[2]
   localparam logic REG_POOL_BYTES = 1'b0;
   localparam logic REG_BLOCK_SIZE = 1'b1;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [FIDX_W-1:0] free_index;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    block_index;
      logic [OFS_W-1:0]    byte_offset;
      logic [CNT_W-1:0]    free_count;
   } rsp_word_type;

   typedef struct packed {
      logic              done;
      logic [POOL_W-1:0] quotient;
   } div_result_type;

endpackage

### hdl/fixed_block_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Pool of fixed-size blocks kept as a linked free list in a link RAM.
// ----------------------------------------------------------------------------
//   port group   direction   word           handshake
//   req_*        in          req_word_type  req_valid / req_stall
//   rsp_*        out         rsp_word_type  rsp_valid / rsp_stall
//   APB          in/out      32-bit regs    psel / penable, pready tied high
//
// Free and reserved-mode items are answered from idle; allocate adds one link RAM read.
// Initialize runs 21 divider steps, then one link RAM write per block.
// One item is in flight at a time.
// Reset empties the list; no RAM clearing pass is needed.
// A stalled result parks in a holding register; req_stall rises until it drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_block_free_list_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  fbpool_pkg::req_word_type          req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output fbpool_pkg::rsp_word_type          rsp_word,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fbpool_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fbpool_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fbpool_pkg::CSR_DATA_W-1:0] prdata,
   output logic                              pready
);
   import fbpool_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_DIV,
      ST_FILL,
      ST_POST
   } state_type;

   state_type          state_ff, state_in;
   logic [POOL_W-1:0]  pool_bytes_ff, pool_bytes_in;
   logic [BSIZE_W-1:0] block_size_ff, block_size_in;
   logic               head_valid_ff, head_valid_in;
   logic [IDX_W-1:0]   head_index_ff, head_index_in;
   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic [BSIZE_W-1:0] stride_ff, stride_in;
   logic [CNT_W-1:0]   free_blocks_ff, free_blocks_in;
   logic [CAP_W-1:0]   cap_new_ff, cap_new_in;
   logic [BSIZE_W-1:0] stride_new_ff, stride_new_in;
   logic [IDX_W-1:0]   fill_idx_ff, fill_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   rsp_word_type       post_ff, post_in;

   logic               req_take;
   logic               out_free;
   logic               res_go;
   rsp_word_type       res_word;
   logic               csr_write;
   logic               fill_last;
   logic [PROD_W-1:0]  offset_prod;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [LINK_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [LINK_W-1:0]  ram_rd_data;

   logic               div_start;
   div_result_type     div_result;

   fbpool_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_index_ff),
      .rd_data (ram_rd_data)
   );

   fbpool_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pool_bytes_ff),
      .divisor  (block_size_ff),
      .result   (div_result)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign csr_write   = psel && penable && pwrite && pready;
   assign fill_last   = (CAP_W'(fill_idx_ff) == CAP_W'(cap_new_ff - 1'b1));
   assign offset_prod = PROD_W'(head_index_ff) * PROD_W'(stride_ff);

   always_comb begin
      state_in       = state_ff;
      pool_bytes_in  = pool_bytes_ff;
      block_size_in  = block_size_ff;
      head_valid_in  = head_valid_ff;
      head_index_in  = head_index_ff;
      capacity_in    = capacity_ff;
      stride_in      = stride_ff;
      free_blocks_in = free_blocks_ff;
      cap_new_in     = cap_new_ff;
      stride_new_in  = stride_new_ff;
      fill_idx_in    = fill_idx_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_word_in    = rsp_word_ff;
      post_in        = post_ff;

      res_go               = 1'b0;
      res_word.status      = STATUS_OK;
      res_word.block_index = '0;
      res_word.byte_offset = '0;
      res_word.free_count  = free_blocks_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = fill_idx_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      div_start   = 1'b0;

      if (csr_write) begin
         case (paddr[2])
            REG_POOL_BYTES: pool_bytes_in = pwdata[POOL_W-1:0];
            REG_BLOCK_SIZE: block_size_in = pwdata[BSIZE_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_word.mode)
                  MODE_ALLOC: begin
                     if (head_valid_ff) begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_ALLOC;
                     end else begin
                        res_go          = 1'b1;
                        res_word.status = STATUS_EMPTY;
                     end
                  end
                  MODE_FREE: begin
                     res_go = 1'b1;
                     if (CAP_W'(req_word.free_index) >= capacity_ff) begin
                        res_word.status = STATUS_NOT_OWNED;
                     end else begin
                        // push: new head points at the old one
                        ram_wr_en     = 1'b1;
                        ram_wr_addr   = req_word.free_index;
                        ram_wr_data   = {!head_valid_ff, head_index_ff};
                        head_index_in = req_word.free_index;
                        head_valid_in = 1'b1;
                        if (free_blocks_ff != COUNT_MAX) begin
                           free_blocks_in = CNT_W'(free_blocks_ff + 1'b1);
                        end
                        res_word.free_count = free_blocks_in;
                     end
                  end
                  MODE_INIT: begin
                     if (block_size_ff < MIN_BLOCK_BYTES) begin
                        res_go          = 1'b1;
                        res_word.status = STATUS_BAD_SETUP;
                     end else begin
                        div_start     = 1'b1;
                        stride_new_in = block_size_ff;
                        state_in      = ST_DIV;
                     end
                  end
                  default: begin
                     res_go = 1'b1;
                  end
               endcase
            end
         end
         ST_ALLOC: begin
            // pop: link RAM word of the old head is now on the read port
            res_go               = 1'b1;
            res_word.block_index = head_index_ff;
            res_word.byte_offset = offset_prod[OFS_W-1:0];
            if (ram_rd_data[LINK_W-1]) begin
               head_valid_in = 1'b0;
               head_index_in = '0;
            end else begin
               head_index_in = ram_rd_data[IDX_W-1:0];
            end
            if (free_blocks_ff != '0) begin
               free_blocks_in = CNT_W'(free_blocks_ff - 1'b1);
            end
            res_word.free_count = free_blocks_in;
         end
         ST_DIV: begin
            if (div_result.done) begin
               if (div_result.quotient == '0 ||
                   div_result.quotient > POOL_W'(MAX_BLOCKS)) begin
                  res_go          = 1'b1;
                  res_word.status = STATUS_BAD_SETUP;
               end else begin
                  cap_new_in  = div_result.quotient[CAP_W-1:0];
                  fill_idx_in = '0;
                  state_in    = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_idx_ff;
            if (fill_last) begin
               ram_wr_data         = {1'b1, {IDX_W{1'b0}}};
               res_go              = 1'b1;
               head_index_in       = '0;
               head_valid_in       = 1'b1;
               capacity_in         = cap_new_ff;
               stride_in           = stride_new_ff;
               free_blocks_in      = CNT_W'(cap_new_ff);
               res_word.free_count = free_blocks_in;
            end else begin
               ram_wr_data = {1'b0, IDX_W'(fill_idx_ff + 1'b1)};
               fill_idx_in = IDX_W'(fill_idx_ff + 1'b1);
            end
         end
         ST_POST: begin
            if (out_free) begin
               rsp_word_in  = post_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hand the finished word to the output, or park it while rsp is stalled
      if (res_go) begin
         if (out_free) begin
            rsp_word_in  = res_word;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            post_in  = res_word;
            state_in = ST_POST;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pool_bytes_ff  <= POOL_W'(4096);
         block_size_ff  <= BSIZE_W'(4);
         head_valid_ff  <= 1'b0;
         head_index_ff  <= '0;
         capacity_ff    <= '0;
         stride_ff      <= '0;
         free_blocks_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pool_bytes_ff  <= pool_bytes_in;
         block_size_ff  <= block_size_in;
         head_valid_ff  <= head_valid_in;
         head_index_ff  <= head_index_in;
         capacity_ff    <= capacity_in;
         stride_ff      <= stride_in;
         free_blocks_ff <= free_blocks_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cap_new_ff    <= cap_new_in;
      stride_new_ff <= stride_new_in;
      fill_idx_ff   <= fill_idx_in;
      rsp_word_ff   <= rsp_word_in;
      post_ff       <= post_in;
   end

   always_comb begin
      case (paddr[2])
         REG_POOL_BYTES: prdata = CSR_DATA_W'(pool_bytes_ff);
         REG_BLOCK_SIZE: prdata = CSR_DATA_W'(block_size_ff);
         default:        prdata = '0;
      endcase
   end

   assign pready    = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // an empty list never carries a nonzero count
   `FB_ASSERT_IMPLIES(a_empty_count, clock, reset, !head_valid_ff, free_blocks_ff == '0)
   // a parked word only exists while the output register is occupied
   `FB_ASSERT_IMPLIES(a_post_full, clock, reset, state_ff == ST_POST, rsp_valid_ff)
   // the divider only finishes while the init sequence waits for it
   `FB_ASSERT_IMPLIES(a_div_owner, clock, reset, div_result.done, state_ff == ST_DIV)
   // fill writes stay inside the new capacity
   `FB_ASSERT_IMPLIES(a_fill_range, clock, reset, state_ff == ST_FILL, CAP_W'(fill_idx_ff) < cap_new_ff)

endmodule

### hdl/fbpool_ram.sv
// ----------------------------------------------------------------------------
// fbpool_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fbpool_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/fbpool_div.sv
// ----------------------------------------------------------------------------
// fbpool_div
// Restoring divider, one quotient bit per cycle, for the pool capacity.
// ----------------------------------------------------------------------------
module fbpool_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fbpool_pkg::POOL_W-1:0]  dividend,
   input  logic [fbpool_pkg::BSIZE_W-1:0] divisor,
   output fbpool_pkg::div_result_type    result
);
   import fbpool_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [POOL_W-1:0]    dq_ff, dq_in;     // dividend bits out, quotient bits in
   logic [BSIZE_W-1:0]   rem_ff, rem_in;
   logic [BSIZE_W-1:0]   dvs_ff, dvs_in;
   logic [BSIZE_W:0]     shifted;
   logic                 ge;

   assign shifted = {rem_ff, dq_ff[POOL_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dq_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? BSIZE_W'(shifted - {1'b0, dvs_ff}) : shifted[BSIZE_W-1:0];
         dq_in  = {dq_ff[POOL_W-2:0], ge};
         cnt_in = DIV_CNT_W'(cnt_ff + 1'b1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign result.done     = done_ff;
   assign result.quotient = dq_ff;

endmodule

### tb/fbpool_result_check.sv
// ----------------------------------------------------------------------------
// fbpool_result_check
// Watches the request, result and register ports of the block pool allocator.
// It keeps its own copy of the free list and the registers, works out the
// result of every accepted request word, and compares each accepted result
// word with the oldest pending one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fbpool_result_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  fbpool_pkg::req_word_type          req_word,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  fbpool_pkg::rsp_word_type          rsp_word,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [fbpool_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fbpool_pkg::CSR_DATA_W-1:0] pwdata,
   output int                                fail_count,
   output int                                outstanding
);
   import fbpool_pkg::*;

   localparam logic [POOL_W-1:0]  POOL_RESET  = POOL_W'(4096);
   localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(4);

   // mirrored registers
   logic [POOL_W-1:0]  pool_reg;
   logic [BSIZE_W-1:0] bsize_reg;

   // free list copy
   logic [IDX_W-1:0]   link_mem [MAX_BLOCKS];
   logic               tail_mem [MAX_BLOCKS];
   logic               head_ok;
   logic [IDX_W-1:0]   head_at;
   logic [CAP_W-1:0]   cap_now;
   logic [BSIZE_W-1:0] stride_now;
   logic [CNT_W-1:0]   free_now;

   rsp_word_type pending_results[$];

   // Apply one request word to the free list copy and return its result.
   function automatic rsp_word_type next_pool_result(req_word_type w);
      rsp_word_type      r;
      logic [IDX_W-1:0]  slot;
      logic [PROD_W-1:0] prod;
      logic [POOL_W-1:0] quot;
      r = '0;
      r.status = STATUS_OK;
      case (w.mode)
         MODE_ALLOC: begin
            if (!head_ok) begin
               r.status = STATUS_EMPTY;
            end else begin
               slot = head_at;
               if (tail_mem[slot]) begin
                  head_ok = 1'b0;
                  head_at = '0;
               end else begin
                  head_at = link_mem[slot];
               end
               if (free_now != '0) free_now = free_now - 1'b1;
               prod = PROD_W'(slot) * PROD_W'(stride_now);
               r.block_index = slot;
               r.byte_offset = prod[OFS_W-1:0];
            end
         end
         MODE_FREE: begin
            if (CAP_W'(w.free_index) >= cap_now) begin
               r.status = STATUS_NOT_OWNED;
            end else begin
               link_mem[w.free_index] = head_at;
               tail_mem[w.free_index] = !head_ok;
               head_at = w.free_index;
               head_ok = 1'b1;
               if (free_now != COUNT_MAX) free_now = free_now + 1'b1;
            end
         end
         MODE_INIT: begin
            quot = '0;
            if (bsize_reg >= MIN_BLOCK_BYTES) quot = pool_reg / POOL_W'(bsize_reg);
            if (bsize_reg < MIN_BLOCK_BYTES || quot == '0 || quot > POOL_W'(MAX_BLOCKS)) begin
               r.status = STATUS_BAD_SETUP;
            end else begin
               for (int k = 0; k < MAX_BLOCKS; k++) begin
                  if (k < quot) begin
                     link_mem[k] = IDX_W'(k + 1);
                     tail_mem[k] = 1'b0;
                  end
               end
               link_mem[quot - 1'b1] = '0;
               tail_mem[quot - 1'b1] = 1'b1;
               head_at = '0;
               head_ok = 1'b1;
               cap_now = CAP_W'(quot);
               stride_now = bsize_reg;
               free_now = CNT_W'(quot);
            end
         end
         default: begin
            // reserved mode: no state change
         end
      endcase
      r.free_count = free_now;
      return r;
   endfunction

   task automatic report(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         pool_reg = POOL_RESET;
         bsize_reg = BSIZE_RESET;
         head_ok = 1'b0;
         head_at = '0;
         cap_now = '0;
         stride_now = '0;
         free_now = '0;
         pending_results.delete();
         outstanding <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[2])
               REG_POOL_BYTES: pool_reg = pwdata[POOL_W-1:0];
               REG_BLOCK_SIZE: bsize_reg = pwdata[BSIZE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report("result word with nothing pending");
            end else begin
               want = pending_results.pop_front();
               check_field("status", 32'(rsp_word.status), 32'(want.status));
               check_field("block_index", 32'(rsp_word.block_index),
                           32'(want.block_index));
               check_field("byte_offset", 32'(rsp_word.byte_offset),
                           32'(want.byte_offset));
               check_field("free_count", 32'(rsp_word.free_count),
                           32'(want.free_count));
            end
         end
         if (req_valid && !req_stall) pending_results.push_back(next_pool_result(req_word));
         outstanding <= pending_results.size();
      end
   end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the fixed-size block pool allocator: directed corner cases,
// then random register settings each followed by an initialize and a mix of
// allocate, free, reserved and initialize words, with random idling on both
// channels. Checking is done by fbpool_result_check.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
   import fbpool_pkg::*;

   localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
   localparam int RANDOM_WORDS = 400;
   localparam int CALM_FROM    = 345;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int fail_count;
   int outstanding;

   int mode_count [4];
   int reg_writes = 0;
   int phases = 0;
   int live_cap = 0;
   bit quiet_tail = 1'b0;
   int send_calm = 0;
   int stall_left = 0;
   int stall_calm = 0;

   always #5 clock = ~clock;

   fixed_block_free_list_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   fbpool_result_check result_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // result side back-pressure: short bursts, with calm stretches
   always @(posedge clock) begin
      if (reset || quiet_tail) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (stall_calm != 0) stall_calm--;
         else if (stall_left == 0 && $urandom_range(0, 99) < 20)
            stall_left = $urandom_range(1, 3);
         else if (stall_left == 0 && $urandom_range(0, 99) < 3)
            stall_calm = $urandom_range(20, 80);
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   task automatic send_word(logic [MODE_W-1:0] m, logic [FIDX_W-1:0] fi);
      req_word_type w;
      w.mode = m;
      w.free_index = fi;
      if (!quiet_tail) begin
         if (send_calm != 0) begin
            send_calm--;
         end else if ($urandom_range(0, 99) < 20) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else if ($urandom_range(0, 99) < 4) begin
            send_calm = $urandom_range(10, 40);
         end
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      mode_count[m]++;
   endtask

   // hold off until every pending result word has come back
   task automatic drain_results;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      reg_writes++;
   endtask

   // reprogram both registers and initialize from them
   task automatic start_phase(int unsigned pool, int unsigned bsize);
      int unsigned cap;
      drain_results();
      write_reg({REG_POOL_BYTES, 2'b00}, pool);
      write_reg({REG_BLOCK_SIZE, 2'b00}, bsize);
      cap = (bsize >= 4) ? pool / bsize : 0;
      if (cap >= 1 && cap <= MAX_BLOCKS) live_cap = cap;
      send_word(MODE_INIT, FIDX_W'($urandom));
      phases++;
   endtask

   initial begin
      int unsigned pool;
      int unsigned bsize;
      int unsigned cap;
      int          rand_sent;
      int          burst;
      int          pick;

      while (reset) @(posedge clock);

      // before any initialize, then the reserved mode
      send_word(MODE_ALLOC, '0);
      send_word(MODE_FREE, '0);
      send_word(MODE_RESERVED, '1);

      // rejected setups: small block, zero capacity, capacity too large
      start_phase(4096, 3);
      start_phase(4096, 65536);
      start_phase(1048576, 4);

      // full pool
      start_phase(4096, 4);
      send_word(MODE_ALLOC, '0);
      send_word(MODE_FREE, 10'd1023);
      send_word(MODE_ALLOC, '0);

      // offsets past 20 bits wrap
      start_phase(2097151, 2048);
      send_word(MODE_FREE, 10'd1022);
      send_word(MODE_ALLOC, '0);
      send_word(MODE_FREE, 10'd1023);

      start_phase(2097151, 131071);
      send_word(MODE_FREE, 10'd15);
      send_word(MODE_ALLOC, '0);

      // single block, empty list, double free
      start_phase(4, 4);
      send_word(MODE_ALLOC, '0);
      send_word(MODE_ALLOC, '0);
      send_word(MODE_FREE, 10'd1);
      send_word(MODE_FREE, 10'd0);
      send_word(MODE_FREE, 10'd0);
      send_word(MODE_ALLOC, '0);
      send_word(MODE_ALLOC, '0);

      rand_sent = 0;
      while (rand_sent < RANDOM_WORDS) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            bsize = $urandom_range(4, 300);
            pool = $urandom_range(1, 40) * bsize + $urandom_range(0, bsize - 1);
         end else if (pick == 6) begin
            bsize = $urandom_range(4, 16);
            pool = $urandom_range(960, MAX_BLOCKS) * bsize + $urandom_range(0, bsize - 1);
         end else if (pick == 7) begin
            case ($urandom_range(0, 2))
               0: begin
                  bsize = $urandom_range(0, 3);
                  pool = $urandom_range(0, 2097151);
               end
               1: begin
                  bsize = $urandom_range(4, 131071);
                  pool = $urandom_range(0, bsize - 1);
               end
               default: begin
                  bsize = $urandom_range(4, 1000);
                  pool = bsize * $urandom_range(1025, 2000);
               end
            endcase
         end else if (pick == 8) begin
            bsize = $urandom_range(32768, 131071);
            pool = $urandom_range(bsize, 2097151);
         end else begin
            bsize = 1 << $urandom_range(10, 16);
            pool = ($urandom_range(0, 1) != 0) ? 1048576 : 2097151;
         end
         start_phase(pool, bsize);
         rand_sent++;

         burst = $urandom_range(20, 45);
         repeat (burst) begin
            if (rand_sent >= CALM_FROM) quiet_tail = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               send_word(MODE_ALLOC, FIDX_W'($urandom));
            end else if (pick < 80) begin
               cap = (live_cap > 0) ? live_cap : MAX_BLOCKS;
               send_word(MODE_FREE, FIDX_W'($urandom_range(0, cap - 1)));
            end else if (pick < 92) begin
               send_word(MODE_FREE, FIDX_W'($urandom));
            end else if (pick < 96) begin
               // answered by the block without a state change, so not counted
               send_word(MODE_RESERVED, FIDX_W'($urandom));
               rand_sent--;
            end else begin
               send_word(MODE_INIT, FIDX_W'($urandom));
            end
            rand_sent++;
         end
      end

      drain_results();
      repeat (30) @(posedge clock);

      $display("summary: %0d allocate, %0d free, %0d initialize, %0d reserved words",
               mode_count[MODE_ALLOC], mode_count[MODE_FREE], mode_count[MODE_INIT],
               mode_count[MODE_RESERVED]);
      $display("summary: %0d register writes over %0d pool setups, %0d mismatches",
               reg_writes, phases, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // watchdog
   initial begin
      #5000000;
      $display("tb: failure");
      $finish;
   end

endmodule
